// File: sv/binary_thinning_pass_defines.svh
// Assertion macros for the port-level checker of the thinning pass.
// No dependencies; sampled on clk and disabled while arst_n is low.
`ifndef BINARY_THINNING_PASS_DEFINES_SVH
`define BINARY_THINNING_PASS_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define BTP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define BTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/btp_pkg.sv
// Shared constants, register codes and the thinning rule of the thinning pass.
// No dependencies; used by the top level and its checker.
package btp_pkg;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	localparam int TDATA_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd1920;
	localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd1080;
	localparam logic [10:0] RST_BAND_START   = 11'd768;
	localparam logic [10:0] RST_BAND_END     = 11'd1152;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_BAND_START    = 3'd2,
		REG_BAND_END      = 3'd3,
		REG_THINNING_MODE = 3'd4,
		REG_SUB_ITERATION = 3'd5
	} btp_reg_t;

	typedef enum logic {
		MODE_ZHANG_SUEN = 1'b0,
		MODE_GUO_HALL   = 1'b1
	} btp_mode_t;

	// Window bit layout: three bits per column, oldest column lowest,
	// top row in the lowest bit of each column.
	function automatic logic btp_delete(input logic [8:0] w, input btp_mode_t mode,
		input logic sub);
		logic p2, p3, p4, p5, p6, p7, p8, p9;
		logic [3:0] a, b, c, n1, n2, n;
		logic m1, m2, m;
		p2 = w[3]; p3 = w[6]; p4 = w[7]; p5 = w[8];
		p6 = w[5]; p7 = w[2]; p8 = w[1]; p9 = w[0];
		a = 4'(!p2 && p3) + 4'(!p3 && p4) + 4'(!p4 && p5) + 4'(!p5 && p6)
			+ 4'(!p6 && p7) + 4'(!p7 && p8) + 4'(!p8 && p9) + 4'(!p9 && p2);
		b = 4'(p2) + 4'(p3) + 4'(p4) + 4'(p5) + 4'(p6) + 4'(p7) + 4'(p8) + 4'(p9);
		m1 = sub ? (p2 & p4 & p8) : (p2 & p4 & p6);
		m2 = sub ? (p2 & p6 & p8) : (p4 & p6 & p8);
		c = 4'(!p2 & (p3 | p4)) + 4'(!p4 & (p5 | p6)) + 4'(!p6 & (p7 | p8))
			+ 4'(!p8 & (p9 | p2));
		n1 = 4'(p9 | p2) + 4'(p3 | p4) + 4'(p5 | p6) + 4'(p7 | p8);
		n2 = 4'(p2 | p3) + 4'(p4 | p5) + 4'(p6 | p7) + 4'(p8 | p9);
		n = (n1 < n2) ? n1 : n2;
		m = sub ? ((p2 | p3 | !p5) & p4) : ((p6 | p7 | !p9) & p8);
		if (mode == MODE_ZHANG_SUEN) begin
			return (a == 4'd1) && (b >= 4'd2) && (b <= 4'd6) && !m1 && !m2;
		end else begin
			return (c == 4'd1) && (n >= 4'd2) && (n <= 4'd3) && !m;
		end
	endfunction

endpackage

// File: sv/binary_thinning_pass.sv
// A pixel's result is computed in stage 1 and queued after the request that completes
// its 3x3 window, i.e. width+1 requests after the pixel itself; flush requests close a frame.
// Throughput: one request per cycle unless s_tready is low, set by the single line memory,
// which takes one read and one write per request. A three-entry output queue absorbs output stalls.
// Reset: counters, window, pipeline and queue control clear; registers take their
// defaults. The line memory is not cleared: unwritten entries only feed row 0.
module binary_thinning_pass
	import btp_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TDATA_W-1:0]    s_tdata,   // [0] pixel_in, rest zero
	input  logic                  s_tuser,   // [0] req_type (1 = flush)
	// Output stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,   // [0] pixel_out, rest zero
	output logic                  m_tlast,   // frame_last
	// Register write port.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Column index, width value, row counter and common arithmetic widths.
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = $clog2(MAX_HEIGHT + 3);
	localparam int SW0 = (RW > WW) ? RW : WW;
	localparam int SW  = ((SW0 > CFG_DATA_W) ? SW0 : CFG_DATA_W) + 1;
	localparam int QD  = 3;

	// Per-request control that travels from the read stage to the write stage.
	typedef struct packed {
		logic emit;     // a result leaves for this request
		logic thin;     // centre lies inside the thinned region
		logic last;     // result is the final pixel of the frame
		logic restart;  // frame state returns to zero after this request
		logic fwd;      // read hit the entry written in the same cycle
	} btp_ctl_t;

	// Registers.
	logic [11:0] image_width_q, image_height_q;
	logic [10:0] band_start_q, band_end_q;
	btp_mode_t   thinning_mode_q;
	logic        sub_iteration_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= RST_IMAGE_WIDTH;
			image_height_q  <= RST_IMAGE_HEIGHT;
			band_start_q    <= RST_BAND_START;
			band_end_q      <= RST_BAND_END;
			thinning_mode_q <= MODE_ZHANG_SUEN;
			sub_iteration_q <= 1'b0;
		end else if (cfg_we) begin
			case (btp_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_data[11:0];
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[11:0];
				REG_BAND_START:    band_start_q    <= cfg_data[10:0];
				REG_BAND_END:      band_end_q      <= cfg_data[10:0];
				REG_THINNING_MODE: thinning_mode_q <= btp_mode_t'(cfg_data[0]);
				REG_SUB_ITERATION: sub_iteration_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective geometry: width and height are clamped to [3, MAX].
	logic [SW-1:0] img_w, img_h, w_e, h_e;
	assign img_w = SW'(image_width_q);
	assign img_h = SW'(image_height_q);
	assign w_e = (img_w < SW'(3)) ? SW'(3) : ((img_w > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : img_w);
	assign h_e = (img_h < SW'(3)) ? SW'(3) :
		((img_h > SW'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT) : img_h);

	// Frame position of the next request. A frame is busy once any request of it
	// has been taken, so a flush outside a frame can be dropped.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          busy_q;

	// Stage 0: the request is accepted, its column is read from the line memory
	// and all position-based decisions are made.
	logic          accept, flush, act, px;
	logic [SW-1:0] col_x, col_c, row_x, r_pos, c_pos;
	logic          pos_valid, restart_geo, last_px, in_rows, in_cols, wraps;
	logic [CW-1:0] col_idx;
	btp_ctl_t      ctl_d;
	logic          act_s1;
	logic [CW-1:0] col_s1;

	assign accept = s_tvalid && s_tready;
	assign flush  = s_tuser;
	assign act    = accept && !(flush && !busy_q);

	always_comb begin
		col_x = SW'(col_q);
		row_x = SW'(row_q);
		// A column counter left past a narrowed width reads as the last column.
		col_c = (col_x >= w_e) ? (w_e - SW'(1)) : col_x;
		col_idx = col_c[CW-1:0];
		// Pixels that arrive once the frame's rows are complete count as flush.
		px = !flush && (row_x < h_e) && s_tdata[0];
		pos_valid = ((col_c != '0) && (row_x != '0)) || ((col_c == '0) && (row_x >= SW'(2)));
		// The window centre lies one row up and one column left of the new pixel;
		// at column 0 it is the last column of the row before that.
		r_pos = (col_c != '0) ? (row_x - SW'(1)) : (row_x - SW'(2));
		c_pos = (col_c != '0) ? (col_c - SW'(1)) : (w_e - SW'(1));
		restart_geo = pos_valid && (r_pos >= h_e);
		last_px = pos_valid && !restart_geo && (r_pos == h_e - SW'(1))
			&& (c_pos == w_e - SW'(1));
		in_rows = (r_pos >= SW'(1)) && (r_pos + SW'(2) <= h_e);
		in_cols = (c_pos >= SW'(1)) && (c_pos + SW'(2) <= w_e)
			&& (c_pos >= SW'(band_start_q)) && (c_pos < SW'(band_end_q));
		wraps = (col_c + SW'(1)) >= w_e;
		ctl_d.emit    = pos_valid && !restart_geo;
		ctl_d.thin    = in_rows && in_cols;
		ctl_d.last    = last_px;
		ctl_d.restart = restart_geo || last_px;
		// The write stage stores this column at the same edge as the read.
		ctl_d.fwd     = act_s1 && (col_s1 == col_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			busy_q <= 1'b0;
		end else if (act) begin
			if (ctl_d.restart) begin
				col_q  <= '0;
				row_q  <= '0;
				busy_q <= 1'b0;
			end else begin
				busy_q <= 1'b1;
				if (wraps) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_idx + CW'(1);
				end
			end
		end
	end

	// Line memory: bit 0 is the upper row, bit 1 the middle row of each column.
	logic [1:0]    row_mem [MAX_WIDTH];
	logic [1:0]    rd_s1, fwd_dat_s1, cur_s1, wr_dat;
	logic          px_s1;
	btp_ctl_t      ctl_s1;

	// A read in the cycle that writes the same column sees the new entry.
	assign cur_s1 = ctl_s1.fwd ? fwd_dat_s1 : rd_s1;
	assign wr_dat = {px_s1, cur_s1[1]};

	always_ff @(posedge clk) begin
		if (act) begin
			rd_s1 <= row_mem[col_idx];
		end
		if (act_s1) begin
			row_mem[col_s1] <= wr_dat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			ctl_s1 <= '0;
		end else begin
			act_s1 <= act;
			if (act) begin
				ctl_s1 <= ctl_d;
			end else begin
				ctl_s1 <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act) begin
			col_s1     <= col_idx;
			px_s1      <= px;
			fwd_dat_s1 <= wr_dat;
		end
	end

	// Stage 1: shift the new column into the window, apply the rule on the
	// original neighbors and write the column back.
	logic [8:0] win_q, win_new;
	logic       pix_res;

	assign win_new = {px_s1, cur_s1[1], cur_s1[0], win_q[8:3]};
	assign pix_res = win_new[4]
		&& !(ctl_s1.thin && btp_delete(win_new, thinning_mode_q, sub_iteration_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (act_s1) begin
			win_q <= ctl_s1.restart ? '0 : win_new;
		end
	end

	// Output queue of {frame_last, pixel_out}. Input is held off only when the
	// queue could not take the result that is still in flight.
	logic [1:0] q_mem [QD];
	logic [1:0] q_wr_q, q_rd_q, q_cnt_q;
	logic       push, pop;

	assign push     = act_s1 && ctl_s1.emit;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (q_cnt_q != '0);
	assign s_tready = !((q_cnt_q == 2'(QD)) || ((q_cnt_q == 2'(QD - 1)) && ctl_s1.emit));
	assign m_tdata  = {{(TDATA_W - 1){1'b0}}, q_mem[q_rd_q][0]};
	assign m_tlast  = q_mem[q_rd_q][1];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[q_wr_q] <= {ctl_s1.last, pix_res};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= '0;
			q_rd_q  <= '0;
			q_cnt_q <= '0;
		end else begin
			if (push) begin
				q_wr_q <= (q_wr_q == 2'(QD - 1)) ? 2'd0 : q_wr_q + 2'd1;
			end
			if (pop) begin
				q_rd_q <= (q_rd_q == 2'(QD - 1)) ? 2'd0 : q_rd_q + 2'd1;
			end
			q_cnt_q <= q_cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: sv/btp_checker.sv
// Port-level checks of the thinning pass, bound to the top level.
// Depends on btp_pkg and the assertion macros in binary_thinning_pass_defines.svh.
`include "binary_thinning_pass_defines.svh"

module btp_checker
	import btp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic               m_tlast
);

	// A stalled result keeps its value.
	`BTP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

	// Input is held off only while results are waiting.
	`BTP_ASSERT_NOW(a_ready_backlog, !s_tready, m_tvalid, "input stalled with empty output")

	// A result appears from an empty queue only for an accepted request, registered in stage 1 and then queued.
	`BTP_ASSERT_NOW(a_out_cause, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without request")

	// Unused result bits stay zero.
	`BTP_ASSERT_NOW(a_out_pad, m_tvalid, m_tdata[TDATA_W-1:1] == '0, "result padding not zero")

endmodule

bind binary_thinning_pass btp_checker u_btp_checker (.*);
